@@ rtl/i2p_pkg.sv @@
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, constants and helper functions of the infix to postfix
// converter: operator codes, precedence, controller commands and status.
// ----------------------------------------------------------------------------
package i2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef logic [2:0] op_code_t;
    typedef logic [2:0] prec_t;
    typedef logic [1:0] err_t;

    localparam op_code_t CODE_NONE = 3'd0;
    localparam op_code_t CODE_OPEN = 3'd1;
    localparam op_code_t CODE_ADD  = 3'd2;
    localparam op_code_t CODE_SUB  = 3'd3;
    localparam op_code_t CODE_MUL  = 3'd4;
    localparam op_code_t CODE_DIV  = 3'd5;
    localparam op_code_t CODE_MOD  = 3'd6;
    localparam op_code_t CODE_POW  = 3'd7;

    localparam err_t ERR_NONE  = 2'd0;
    localparam err_t ERR_CLOSE = 2'd1;
    localparam err_t ERR_OVF   = 2'd2;
    localparam err_t ERR_OPEN  = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MOD   = 8'h25;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;

    localparam prec_t PREC_ZERO  = 3'd0;
    localparam prec_t PREC_ADD   = 3'd1;
    localparam prec_t PREC_MUL   = 3'd2;
    localparam prec_t PREC_POW   = 3'd3;
    // '(' as incoming item pops nothing
    localparam prec_t PREC_NOPOP = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPACE,
        S_POP,
        S_TAIL,
        S_OPERAND,
        S_END_POP,
        S_END_MARK
    } state_t;

    typedef enum logic [1:0] {
        EM_SPACE,
        EM_CHAR,
        EM_TOP,
        EM_MARK
    } emit_sel_t;

    typedef struct packed {
        logic      use_input;
        logic      latch;
        logic      emit;
        emit_sel_t emit_sel;
        logic      last;
        logic      done;
        logic      push;
        logic      pop;
        logic      set_err;
        err_t      err_code;
        logic      set_inop;
        logic      clear_inop;
        logic      clear_all;
    } cmd_t;

    typedef struct packed {
        logic in_end;
        logic in_ignore;
        logic in_operand;
        logic item_end;
        logic item_close;
        logic inop;
        logic err_set;
        logic pop_go;
        logic pop_more;
        logic marker_now;
        logic marker_after_pop;
        logic top_open;
        logic cnt_zero;
        logic out_free;
    } stat_t;

    function automatic op_code_t char_code(input logic [7:0] c);
        op_code_t r;
        case (c)
            CH_OPEN: r = CODE_OPEN;
            CH_ADD:  r = CODE_ADD;
            CH_SUB:  r = CODE_SUB;
            CH_MUL:  r = CODE_MUL;
            CH_DIV:  r = CODE_DIV;
            CH_MOD:  r = CODE_MOD;
            CH_POW:  r = CODE_POW;
            default: r = CODE_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_char(input op_code_t code);
        logic [7:0] r;
        case (code)
            CODE_OPEN: r = CH_OPEN;
            CODE_ADD:  r = CH_ADD;
            CODE_SUB:  r = CH_SUB;
            CODE_MUL:  r = CH_MUL;
            CODE_DIV:  r = CH_DIV;
            CODE_MOD:  r = CH_MOD;
            CODE_POW:  r = CH_POW;
            default:   r = CH_NUL;
        endcase
        return r;
    endfunction

    function automatic prec_t prec_of(input op_code_t code);
        prec_t r;
        case (code)
            CODE_POW: r = PREC_POW;
            CODE_MUL: r = PREC_MUL;
            CODE_DIV: r = PREC_MUL;
            CODE_MOD: r = PREC_MUL;
            CODE_ADD: r = PREC_ADD;
            CODE_SUB: r = PREC_ADD;
            default:  r = PREC_ZERO;
        endcase
        return r;
    endfunction

    // stacked entry gets popped by an item of precedence p
    function automatic logic can_pop(input op_code_t entry, input prec_t p);
        return (entry != CODE_OPEN) && (prec_of(entry) >= p);
    endfunction

endpackage

@@ rtl/i2p_datapath.sv @@
// ----------------------------------------------------------------------------
// i2p_datapath
// Item register, operator stack with cached top and second entries, sticky
// error and operand flags, and the output register.
// ----------------------------------------------------------------------------
module i2p_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_char,
    input  logic             in_end,
    input  i2p_pkg::cmd_t    cmd,
    output i2p_pkg::stat_t   stat,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [7:0]       out_char,
    output logic             out_char_valid,
    output logic             out_last,
    output logic             out_done,
    output i2p_pkg::err_t    out_err
);

    logic [7:0]                   item_char_reg;
    i2p_pkg::op_code_t            item_code_reg;
    logic                         item_close_reg;
    logic                         item_end_reg;

    logic [i2p_pkg::CNT_W-1:0]    cnt_reg;
    logic [i2p_pkg::CNT_W-1:0]    cnt_next;
    i2p_pkg::op_code_t            top_reg;
    i2p_pkg::op_code_t            top_next;
    i2p_pkg::op_code_t            sec_reg;
    i2p_pkg::op_code_t            mem [i2p_pkg::STACK_DEPTH];
    logic [i2p_pkg::CNT_W-1:0]    rd_full;
    logic [i2p_pkg::STK_AW-1:0]   rd_addr;
    logic [i2p_pkg::STK_AW-1:0]   wr_addr;

    i2p_pkg::err_t                error_reg;
    i2p_pkg::err_t                error_next;
    logic                         inop_reg;
    logic                         inop_next;

    logic                         out_valid_reg;
    logic [7:0]                   out_char_reg;
    logic                         out_cv_reg;
    logic                         out_last_reg;
    logic                         out_done_reg;
    i2p_pkg::err_t                out_err_reg;
    logic [7:0]                   emit_char;
    logic                         out_free;

    i2p_pkg::op_code_t            live_code;
    logic                         live_close;
    logic                         live_ws;
    i2p_pkg::op_code_t            cur_code;
    logic                         cur_close;
    i2p_pkg::prec_t               cur_p;

    assign live_code  = i2p_pkg::char_code(in_char);
    assign live_close = (in_char == i2p_pkg::CH_CLOSE);
    assign live_ws    = (in_char == i2p_pkg::CH_SPACE) || (in_char == i2p_pkg::CH_TAB);

    assign cur_code  = cmd.use_input ? live_code  : item_code_reg;
    assign cur_close = cmd.use_input ? live_close : item_close_reg;

    always_comb
    begin
        if (cur_close)
        begin
            cur_p = i2p_pkg::PREC_ZERO;
        end
        else if (cur_code == i2p_pkg::CODE_OPEN)
        begin
            cur_p = i2p_pkg::PREC_NOPOP;
        end
        else
        begin
            cur_p = i2p_pkg::prec_of(cur_code);
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        stat.in_end           = in_end;
        stat.in_ignore        = (error_reg != i2p_pkg::ERR_NONE) || live_ws;
        stat.in_operand       = (live_code == i2p_pkg::CODE_NONE) && !live_close;
        stat.item_end         = item_end_reg;
        stat.item_close       = item_close_reg;
        stat.inop             = inop_reg;
        stat.err_set          = (error_reg != i2p_pkg::ERR_NONE);
        stat.pop_go           = (cnt_reg != '0) && i2p_pkg::can_pop(top_reg, cur_p);
        stat.pop_more         = (cnt_reg > i2p_pkg::CNT_W'(1))
                                && i2p_pkg::can_pop(sec_reg, cur_p);
        stat.marker_now       = cur_close ? (cnt_reg == '0)
                                          : (cnt_reg == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH));
        stat.marker_after_pop = cur_close && (cnt_reg == i2p_pkg::CNT_W'(1));
        stat.top_open         = (top_reg == i2p_pkg::CODE_OPEN);
        stat.cnt_zero         = (cnt_reg == '0);
        stat.out_free         = out_free;
    end

    // stack pointer and cached top; second entry follows from memory
    always_comb
    begin
        cnt_next = cnt_reg;
        top_next = top_reg;
        if (cmd.clear_all)
        begin
            cnt_next = '0;
        end
        else if (cmd.push)
        begin
            cnt_next = cnt_reg + i2p_pkg::CNT_W'(1);
            top_next = cur_code;
        end
        else if (cmd.pop)
        begin
            cnt_next = cnt_reg - i2p_pkg::CNT_W'(1);
            top_next = sec_reg;
        end
    end

    assign rd_full = cnt_next - i2p_pkg::CNT_W'(2);
    assign rd_addr = rd_full[i2p_pkg::STK_AW-1:0];
    assign wr_addr = cnt_reg[i2p_pkg::STK_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_addr] <= cur_code;
        end
        sec_reg <= mem[rd_addr];
    end

    always_comb
    begin
        error_next = error_reg;
        inop_next  = inop_reg;
        if (cmd.clear_all)
        begin
            error_next = i2p_pkg::ERR_NONE;
            inop_next  = 1'b0;
        end
        else
        begin
            if (cmd.set_err)
            begin
                error_next = cmd.err_code;
            end
            if (cmd.clear_inop)
            begin
                inop_next = 1'b0;
            end
            else if (cmd.set_inop)
            begin
                inop_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (cmd.emit_sel)
            i2p_pkg::EM_SPACE: emit_char = i2p_pkg::CH_SPACE;
            i2p_pkg::EM_CHAR:  emit_char = item_char_reg;
            i2p_pkg::EM_TOP:   emit_char = i2p_pkg::code_char(top_reg);
            i2p_pkg::EM_MARK:  emit_char = i2p_pkg::CH_NUL;
            default:           emit_char = i2p_pkg::CH_NUL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            error_reg     <= i2p_pkg::ERR_NONE;
            inop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            error_reg <= error_next;
            inop_reg  <= inop_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (cmd.latch)
        begin
            item_char_reg  <= in_char;
            item_code_reg  <= live_code;
            item_close_reg <= live_close;
            item_end_reg   <= in_end;
        end
        if (cmd.emit)
        begin
            out_char_reg <= emit_char;
            out_cv_reg   <= (cmd.emit_sel != i2p_pkg::EM_MARK);
            out_last_reg <= cmd.last;
            out_done_reg <= cmd.done;
            out_err_reg  <= cmd.set_err ? cmd.err_code : error_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_char       = out_char_reg;
    assign out_char_valid = out_cv_reg;
    assign out_last       = out_last_reg;
    assign out_done       = out_done_reg;
    assign out_err        = out_err_reg;

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (cnt_reg < i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH)))
        else $error("push onto full stack");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (cnt_reg != '0))
        else $error("pop from empty stack");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("output register overwritten");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.done) |=> ((cnt_reg == '0) && (error_reg == i2p_pkg::ERR_NONE)
                                    && !inop_reg))
        else $error("state not cleared after end of expression");

endmodule

@@ rtl/i2p_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer: accepts one character per request, then steps through operand
// close, stack pops, push or close and end-of-expression drain.
// ----------------------------------------------------------------------------
module i2p_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  i2p_pkg::stat_t   stat,
    output i2p_pkg::cmd_t    cmd
);

    i2p_pkg::state_t state_reg;
    i2p_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2p_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == i2p_pkg::S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.emit_sel = i2p_pkg::EM_MARK;
        cmd.err_code = i2p_pkg::ERR_NONE;
        case (state_reg)
            i2p_pkg::S_IDLE:
            begin
                cmd.use_input = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    if (stat.in_end)
                    begin
                        if (stat.err_set)
                            state_next = i2p_pkg::S_END_MARK;
                        else if (stat.inop)
                            state_next = i2p_pkg::S_SPACE;
                        else
                            state_next = i2p_pkg::S_END_POP;
                    end
                    else if (stat.in_ignore)
                        state_next = i2p_pkg::S_IDLE;
                    else if (stat.in_operand)
                        state_next = i2p_pkg::S_OPERAND;
                    else if (stat.inop)
                        state_next = i2p_pkg::S_SPACE;
                    else if (stat.pop_go)
                        state_next = i2p_pkg::S_POP;
                    else
                        state_next = i2p_pkg::S_TAIL;
                end
            end
            i2p_pkg::S_SPACE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = i2p_pkg::EM_SPACE;
                    cmd.clear_inop = 1'b1;
                    cmd.last       = !stat.item_end && !stat.pop_go && !stat.marker_now;
                    if (stat.item_end)
                        state_next = i2p_pkg::S_END_POP;
                    else if (stat.pop_go)
                        state_next = i2p_pkg::S_POP;
                    else
                        state_next = i2p_pkg::S_TAIL;
                end
            end
            i2p_pkg::S_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = i2p_pkg::EM_TOP;
                    cmd.pop      = 1'b1;
                    cmd.last     = !stat.pop_more && !stat.marker_after_pop;
                    state_next   = stat.pop_more ? i2p_pkg::S_POP : i2p_pkg::S_TAIL;
                end
            end
            i2p_pkg::S_TAIL:
            begin
                if (!stat.marker_now)
                begin
                    cmd.pop    = stat.item_close;
                    cmd.push   = !stat.item_close;
                    state_next = i2p_pkg::S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = stat.item_close ? i2p_pkg::ERR_CLOSE : i2p_pkg::ERR_OVF;
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = i2p_pkg::EM_MARK;
                    cmd.last     = 1'b1;
                    state_next   = i2p_pkg::S_IDLE;
                end
            end
            i2p_pkg::S_OPERAND:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = i2p_pkg::EM_CHAR;
                    cmd.last     = 1'b1;
                    cmd.set_inop = 1'b1;
                    state_next   = i2p_pkg::S_IDLE;
                end
            end
            i2p_pkg::S_END_POP:
            begin
                if (stat.cnt_zero)
                begin
                    state_next = i2p_pkg::S_END_MARK;
                end
                else if (stat.top_open)
                begin
                    cmd.pop      = 1'b1;
                    cmd.set_err  = 1'b1;
                    cmd.err_code = i2p_pkg::ERR_OPEN;
                end
                else if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = i2p_pkg::EM_TOP;
                    cmd.pop      = 1'b1;
                end
            end
            i2p_pkg::S_END_MARK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = i2p_pkg::EM_MARK;
                    cmd.last      = 1'b1;
                    cmd.done      = 1'b1;
                    cmd.clear_all = 1'b1;
                    state_next    = i2p_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = i2p_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/infix_to_postfix_converter.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix character stream to postfix text.
// ----------------------------------------------------------------------------
// Input channel s_axis: one expression character per request; tlast marks
// the end of the expression (character ignored, drains the operator stack).
// Output channel m_axis: one postfix character or marker per request.
// tuser flags a real character, tlast marks the last result of an input
// request, tdata carries the expression-done bit and the sticky error code.
// Work per input request:
//   space, tab, or any character after an error: ignored, nothing emitted
//   operand character: echoed; '(' or an operator with nothing to pop: pushed
//   operator or ')': a space first when an operand is open, then each
//   popped stack entry (one stack entry leaves per cycle while the output is free)
//   end marker: a space for an open operand, every stacked operator, then the
//   done marker; only the marker when an error is already set
// Each result is registered in the output register; an end marker drops every
// stacked '(' without a result and sets the open error.
// Reset empties the stack and clears the error and operand state; stack
// memory contents are not cleared. When m_axis_tready is low the pending
// result holds in the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_out, [8] expr_done, [10:9] error_code
    output logic        m_axis_tuser,   // [0] char_valid
    output logic        m_axis_tlast
);

    i2p_pkg::cmd_t  cmd;
    i2p_pkg::stat_t stat;
    logic [7:0]     out_char;
    logic           out_done;
    i2p_pkg::err_t  out_err;

    i2p_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    i2p_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_char        (s_axis_tdata),
        .in_end         (s_axis_tlast),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_char       (out_char),
        .out_char_valid (m_axis_tuser),
        .out_last       (m_axis_tlast),
        .out_done       (out_done),
        .out_err        (out_err)
    );

    assign m_axis_tdata = {5'b0, out_err, out_done, out_char};

endmodule

@@ sim/tb_infix_to_postfix_converter.sv @@
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter
// Self-checking bench for the infix to postfix converter. A directed table
// (reset state, byte extremes, every operator, both bracket errors) is followed
// by random expressions: mostly well-formed formulas, with deep nesting
// around the stack limit and some noise. A shunting-yard predictor builds
// the expected postfix stream, which is checked field by field while both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter;

    typedef struct packed {
        logic [7:0]    ch;
        logic          valid;
        logic          last;
        logic          done;
        i2p_pkg::err_t err;
    } postfix_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoe;
        logic       typed;
        postfix_t   want;
    } req_t;

    localparam int       IDLE_LIMIT   = 4000;
    localparam int       DRAIN_CYCLES = 64;
    localparam int       RAND_ITEMS   = 205;
    localparam postfix_t ANY          = '0;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    infix_to_postfix_converter DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // predictor state
    i2p_pkg::op_code_t op_stk [i2p_pkg::STACK_DEPTH];
    int unsigned       stk_cnt      = 0;
    bit                operand_open = 1'b0;
    i2p_pkg::err_t     sticky_err   = i2p_pkg::ERR_NONE;

    postfix_t step_q    [$];
    postfix_t postfix_q [$];
    req_t     chars_q   [$];
    req_t     dir_tab   [0:21];

    int unsigned acc_idx  = 0;
    int          phase    = 0;
    int          idle_cnt = 0;
    int          rand_cnt = 0;
    bit          failed   = 1'b0;

    function automatic i2p_pkg::op_code_t op_of(input logic [7:0] c);
        case (c)
            i2p_pkg::CH_OPEN: return i2p_pkg::CODE_OPEN;
            i2p_pkg::CH_ADD:  return i2p_pkg::CODE_ADD;
            i2p_pkg::CH_SUB:  return i2p_pkg::CODE_SUB;
            i2p_pkg::CH_MUL:  return i2p_pkg::CODE_MUL;
            i2p_pkg::CH_DIV:  return i2p_pkg::CODE_DIV;
            i2p_pkg::CH_MOD:  return i2p_pkg::CODE_MOD;
            i2p_pkg::CH_POW:  return i2p_pkg::CODE_POW;
            default:          return i2p_pkg::CODE_NONE;
        endcase
    endfunction

    function automatic logic [7:0] glyph(input i2p_pkg::op_code_t k);
        case (k)
            i2p_pkg::CODE_ADD: return i2p_pkg::CH_ADD;
            i2p_pkg::CODE_SUB: return i2p_pkg::CH_SUB;
            i2p_pkg::CODE_MUL: return i2p_pkg::CH_MUL;
            i2p_pkg::CODE_DIV: return i2p_pkg::CH_DIV;
            i2p_pkg::CODE_MOD: return i2p_pkg::CH_MOD;
            i2p_pkg::CODE_POW: return i2p_pkg::CH_POW;
            default:           return i2p_pkg::CH_NUL;
        endcase
    endfunction

    function automatic int rank(input i2p_pkg::op_code_t k);
        case (k)
            i2p_pkg::CODE_POW:                                      return 3;
            i2p_pkg::CODE_MUL, i2p_pkg::CODE_DIV, i2p_pkg::CODE_MOD: return 2;
            i2p_pkg::CODE_ADD, i2p_pkg::CODE_SUB:                   return 1;
            default:                                                return 0;
        endcase
    endfunction

    task automatic put(input logic [7:0] c, input logic valid, input logic done);
        step_q.push_back('{valid ? c : i2p_pkg::CH_NUL, valid, 1'b0, done, sticky_err});
    endtask

    task automatic end_operand();
        if (operand_open)
        begin
            put(i2p_pkg::CH_SPACE, 1'b1, 1'b0);
            operand_open = 1'b0;
        end
    endtask

    // one input request through the shunting-yard; results land in step_q
    task automatic shunt(input logic [7:0] c, input logic eoe);
        i2p_pkg::op_code_t k;
        postfix_t r;
        step_q.delete();
        if (eoe)
        begin
            if (sticky_err == i2p_pkg::ERR_NONE)
            begin
                end_operand();
                while (stk_cnt > 0)
                begin
                    stk_cnt--;
                    if (op_stk[stk_cnt] == i2p_pkg::CODE_OPEN)
                        sticky_err = i2p_pkg::ERR_OPEN;
                    else
                        put(glyph(op_stk[stk_cnt]), 1'b1, 1'b0);
                end
            end
            put(i2p_pkg::CH_NUL, 1'b0, 1'b1);
            stk_cnt      = 0;
            operand_open = 1'b0;
            sticky_err   = i2p_pkg::ERR_NONE;
        end
        else if (sticky_err != i2p_pkg::ERR_NONE || c == i2p_pkg::CH_SPACE
                 || c == i2p_pkg::CH_TAB)
        begin
        end
        else if (c == i2p_pkg::CH_CLOSE)
        begin
            end_operand();
            while (stk_cnt > 0 && op_stk[stk_cnt-1] != i2p_pkg::CODE_OPEN)
            begin
                put(glyph(op_stk[stk_cnt-1]), 1'b1, 1'b0);
                stk_cnt--;
            end
            if (stk_cnt > 0)
                stk_cnt--;
            else
            begin
                sticky_err = i2p_pkg::ERR_CLOSE;
                put(i2p_pkg::CH_NUL, 1'b0, 1'b0);
            end
        end
        else
        begin
            k = op_of(c);
            if (k == i2p_pkg::CODE_NONE)
            begin
                put(c, 1'b1, 1'b0);
                operand_open = 1'b1;
            end
            else
            begin
                end_operand();
                if (k != i2p_pkg::CODE_OPEN)
                    while (stk_cnt > 0 && op_stk[stk_cnt-1] != i2p_pkg::CODE_OPEN
                           && rank(op_stk[stk_cnt-1]) >= rank(k))
                    begin
                        put(glyph(op_stk[stk_cnt-1]), 1'b1, 1'b0);
                        stk_cnt--;
                    end
                if (stk_cnt < i2p_pkg::STACK_DEPTH)
                begin
                    op_stk[stk_cnt] = k;
                    stk_cnt++;
                end
                else
                begin
                    sticky_err = i2p_pkg::ERR_OVF;
                    put(i2p_pkg::CH_NUL, 1'b0, 1'b0);
                end
            end
        end
        if (step_q.size() > 0)
        begin
            r      = step_q.pop_back();
            r.last = 1'b1;
            step_q.push_back(r);
        end
    endtask

    // ---------------- stimulus generation ----------------
    function automatic bit roll(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic bit is_special(input logic [7:0] c);
        return c == i2p_pkg::CH_SPACE || c == i2p_pkg::CH_TAB || c == i2p_pkg::CH_CLOSE
               || op_of(c) != i2p_pkg::CODE_NONE;
    endfunction

    function automatic logic [7:0] operand_char();
        logic [7:0] c;
        do
        begin
            if (roll(50))
                c = 8'h61 + 8'($urandom_range(25, 0));
            else
                c = 8'($urandom_range(255, 0));
        end
        while (is_special(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_op();
        case ($urandom_range(5, 0))
            0:       return i2p_pkg::CH_ADD;
            1:       return i2p_pkg::CH_SUB;
            2:       return i2p_pkg::CH_MUL;
            3:       return i2p_pkg::CH_DIV;
            4:       return i2p_pkg::CH_MOD;
            default: return i2p_pkg::CH_POW;
        endcase
    endfunction

    task automatic queue_char(input logic [7:0] c, input logic eoe);
        chars_q.push_back('{c, eoe, 1'b0, ANY});
        rand_cnt++;
    endtask

    task automatic maybe_blank();
        if (roll(15))
            queue_char(roll(50) ? i2p_pkg::CH_SPACE : i2p_pkg::CH_TAB, 1'b0);
    endtask

    task automatic gen_deep(input int depth);
        int i;
        for (i = 0; i < depth; i++)
            queue_char(i2p_pkg::CH_OPEN, 1'b0);
        queue_char(operand_char(), 1'b0);
        if (roll(50))
        begin
            queue_char(pick_op(), 1'b0);
            queue_char(operand_char(), 1'b0);
        end
        for (i = 0; i < depth; i++)
            queue_char(i2p_pkg::CH_CLOSE, 1'b0);
        queue_char(8'($urandom_range(255, 0)), 1'b1);
    endtask

    task automatic gen_formula();
        int terms;
        int depth;
        int t;
        int k;
        int n;
        depth = 0;
        terms = $urandom_range(6, 1);
        for (t = 0; t < terms; t++)
        begin
            n = $urandom_range(2, 0);
            for (k = 0; k < n && depth < 8; k++)
            begin
                queue_char(i2p_pkg::CH_OPEN, 1'b0);
                depth++;
                maybe_blank();
            end
            n = $urandom_range(3, 1);
            for (k = 0; k < n; k++)
                queue_char(operand_char(), 1'b0);
            maybe_blank();
            n = $urandom_range(depth, 0);
            for (k = 0; k < n; k++)
            begin
                queue_char(i2p_pkg::CH_CLOSE, 1'b0);
                depth--;
            end
            if (t < terms - 1)
            begin
                queue_char(pick_op(), 1'b0);
                maybe_blank();
            end
        end
        if (!roll(10))
        begin
            while (depth > 0)
            begin
                queue_char(i2p_pkg::CH_CLOSE, 1'b0);
                depth--;
            end
            if (roll(5))
                queue_char(i2p_pkg::CH_CLOSE, 1'b0);
        end
        queue_char(8'($urandom_range(255, 0)), 1'b1);
    endtask

    task automatic gen_noise();
        int n;
        int k;
        logic [7:0] c;
        n = $urandom_range(12, 3);
        for (k = 0; k < n; k++)
        begin
            if (roll(30))
                c = 8'($urandom_range(255, 0));
            else
                case ($urandom_range(4, 0))
                    0:       c = i2p_pkg::CH_SPACE;
                    1:       c = i2p_pkg::CH_TAB;
                    2:       c = i2p_pkg::CH_OPEN;
                    3:       c = i2p_pkg::CH_CLOSE;
                    default: c = pick_op();
                endcase
            queue_char(c, 1'b0);
        end
        if (roll(85))
            queue_char(8'($urandom_range(255, 0)), 1'b1);
    endtask

    // ---------------- idling ----------------
    function automatic bit send_idle();
        return roll(phase == 1 ? 69 : phase == 3 ? 21 : 0);
    endfunction

    always @(posedge clk)
        m_axis_tready <= !roll(phase == 2 ? 69 : phase == 3 ? 21 : 0);

    // ---------------- checking ----------------
    task automatic check(input string what, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin : mon
        postfix_t got;
        postfix_t w;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                shunt(chars_q[acc_idx].ch, chars_q[acc_idx].eoe);
                if (chars_q[acc_idx].typed)
                    postfix_q.push_back(chars_q[acc_idx].want);
                else
                    foreach (step_q[j])
                        postfix_q.push_back(step_q[j]);
                acc_idx++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tdata[7:0], m_axis_tuser, m_axis_tlast,
                        m_axis_tdata[8], m_axis_tdata[10:9]};
                if (postfix_q.size() == 0)
                begin
                    $display("%0t: unexpected result expected none got %h", $time, got);
                    failed = 1'b1;
                end
                else
                begin
                    w = postfix_q.pop_front();
                    check("char_out", w.ch, got.ch);
                    check("char_valid", 8'(w.valid), 8'(got.valid));
                    check("run_last", 8'(w.last), 8'(got.last));
                    check("expr_done", 8'(w.done), 8'(got.done));
                    check("error_code", 8'(w.err), 8'(got.err));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ---------------- main sequence ----------------
    initial
    begin
        int i;
        int n_expr;
        int sel;
        dir_tab = '{
            '{i2p_pkg::CH_NUL,   1'b1, 1'b1,
              '{i2p_pkg::CH_NUL, 1'b0, 1'b1, 1'b1, i2p_pkg::ERR_NONE}},
            '{i2p_pkg::CH_CLOSE, 1'b0, 1'b1,
              '{i2p_pkg::CH_NUL, 1'b0, 1'b1, 1'b0, i2p_pkg::ERR_CLOSE}},
            '{8'h61,             1'b0, 1'b0, ANY},
            '{8'hFF,             1'b1, 1'b1,
              '{i2p_pkg::CH_NUL, 1'b0, 1'b1, 1'b1, i2p_pkg::ERR_CLOSE}},
            '{8'h00,             1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, i2p_pkg::ERR_NONE}},
            '{8'hFF,             1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0, i2p_pkg::ERR_NONE}},
            '{i2p_pkg::CH_ADD,   1'b0, 1'b0, ANY},
            '{i2p_pkg::CH_OPEN,  1'b0, 1'b0, ANY},
            '{i2p_pkg::CH_TAB,   1'b0, 1'b0, ANY},
            '{8'h62,             1'b0, 1'b0, ANY},
            '{i2p_pkg::CH_SUB,   1'b0, 1'b0, ANY},
            '{i2p_pkg::CH_SPACE, 1'b0, 1'b0, ANY},
            '{8'h63,             1'b0, 1'b0, ANY},
            '{i2p_pkg::CH_CLOSE, 1'b0, 1'b0, ANY},
            '{i2p_pkg::CH_MUL,   1'b0, 1'b0, ANY},
            '{i2p_pkg::CH_DIV,   1'b0, 1'b0, ANY},
            '{i2p_pkg::CH_MOD,   1'b0, 1'b0, ANY},
            '{i2p_pkg::CH_POW,   1'b0, 1'b0, ANY},
            '{8'h64,             1'b0, 1'b0, ANY},
            '{i2p_pkg::CH_POW,   1'b0, 1'b0, ANY},
            '{i2p_pkg::CH_OPEN,  1'b0, 1'b0, ANY},
            '{8'h00,             1'b1, 1'b0, ANY}
        };
        foreach (dir_tab[r])
            chars_q.push_back(dir_tab[r]);
        n_expr = 0;
        while (rand_cnt < RAND_ITEMS)
        begin
            sel = $urandom_range(99, 0);
            if (n_expr == 0)
                gen_deep(i2p_pkg::STACK_DEPTH + 1);
            else if (n_expr == 1)
                gen_deep(i2p_pkg::STACK_DEPTH);
            else if (sel < 7)
                gen_deep($urandom_range(i2p_pkg::STACK_DEPTH + 2, i2p_pkg::STACK_DEPTH - 4));
            else if (sel < 22)
                gen_noise();
            else
                gen_formula();
            n_expr++;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < chars_q.size(); i++)
        begin
            phase = (i * 4) / chars_q.size();
            while (send_idle())
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= chars_q[i].ch;
            s_axis_tlast  <= chars_q[i].eoe;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b0;

        while (postfix_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failed)
            $display("== FAIL ==");
        else
            $display("== PASS ==");
        $finish;
    end

endmodule
